// ===== hdl/ssil_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssil_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int POS_W = 9;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/ssil_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssil_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssil_cmp (
    input  wire logic signed [ssil_pkg::VAL_W-1:0] a,
    input  wire logic signed [ssil_pkg::VAL_W-1:0] b,
    output ssil_pkg::cmp_t                          res
);
    import ssil_pkg::*;

    // signed (two's complement) compare, shared by every search step
    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

`default_nettype wire

// ===== hdl/ssil_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssil_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         in_mode,
    input  wire logic signed [ssil_pkg::VAL_W-1:0]  in_value,
    output logic                                    rd_en,
    output logic [ssil_pkg::IDX_W-1:0]              rd_addr,
    input  wire logic [ssil_pkg::VAL_W-1:0]         rd_data,
    output logic                                    wr_en,
    output logic [ssil_pkg::IDX_W-1:0]              wr_addr,
    output logic [ssil_pkg::VAL_W-1:0]              wr_data,
    output logic signed [ssil_pkg::VAL_W-1:0]       cmp_a,
    output logic signed [ssil_pkg::VAL_W-1:0]       cmp_b,
    input  ssil_pkg::cmp_t                          cmp_res,
    output logic                                    res_valid,
    input  wire logic                               res_taken,
    output ssil_pkg::result_t                       res
);
    import ssil_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SRCH_RD  = 6'b000010,
        S_SRCH_CMP = 6'b000100,
        S_SHIFT    = 6'b001000,
        S_DRAIN    = 6'b010000,
        S_PLACE    = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    state_t                  state_reg, state_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic                    eq_reg, eq_next;
    logic                    ins_reg, ins_next;
    logic [VAL_W-1:0]        key_reg, key_next;
    logic [IDX_W-1:0]        rp_reg, rp_next;
    logic [IDX_W-1:0]        wa_reg, wa_next;
    logic                    pend_reg, pend_next;
    result_t                 res_reg, res_next;

    logic [CNT_W-1:0]        span;
    logic [CNT_W-1:0]        mid;

    assign span = hi_reg - lo_reg;
    assign mid  = lo_reg + (span >> 1);

    assign cmp_a     = signed'(rd_data);
    assign cmp_b     = signed'(key_reg);
    assign in_ready  = (state_reg == S_IDLE) && !done_reg;
    assign res_valid = done_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        eq_next    = eq_reg;
        ins_next   = ins_reg;
        key_next   = key_reg;
        rp_next    = rp_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = rp_reg;
        wr_en      = 1'b0;
        wr_addr    = wa_reg;
        wr_data    = rd_data;

        if (done_reg && res_taken)
        begin
            done_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    key_next = in_value;
                    ins_next = (in_mode == MODE_INSERT);
                    if (in_mode == MODE_CLEAR)
                    begin
                        count_next = '0;
                        res_next   = '{ST_CLEARED, '0, '0};
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        eq_next    = 1'b0;
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[IDX_W-1:0];
                    mid_next   = mid;
                    state_next = S_SRCH_CMP;
                end
                else if (ins_reg && !eq_reg && (count_reg != DEPTH_C))
                begin
                    // room to insert: shift the tail if the value is not last
                    if (count_reg == lo_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rp_next    = IDX_W'(count_reg - ONE_C);
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    res_next.position    = POS_W'(lo_reg);
                    res_next.entry_count = POS_W'(count_reg);
                    if (ins_reg)
                    begin
                        res_next.status = eq_reg ? ST_DUPLICATE : ST_FULL;
                    end
                    else
                    begin
                        res_next.status = eq_reg ? ST_FOUND : ST_NOT_FOUND;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SRCH_CMP:
            begin
                if (cmp_res.lt)
                begin
                    lo_next = mid_reg + ONE_C;
                end
                else
                begin
                    hi_next = mid_reg;
                    eq_next = cmp_res.eq;
                end
                state_next = S_SRCH_RD;
            end
            S_SHIFT:
            begin
                // read one below while the previous read lands one above
                rd_en     = 1'b1;
                rd_addr   = rp_reg;
                wr_en     = pend_reg;
                pend_next = 1'b1;
                wa_next   = rp_reg + 1'b1;
                if (rp_reg == lo_reg[IDX_W-1:0])
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rp_next = rp_reg - 1'b1;
                end
            end
            S_DRAIN:
            begin
                wr_en      = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[IDX_W-1:0];
                wr_data    = key_reg;
                count_next = count_reg + ONE_C;
                res_next   = '{ST_INSERTED, POS_W'(lo_reg), POS_W'(count_reg + ONE_C)};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        eq_reg  <= eq_next;
        ins_reg <= ins_next;
        key_reg <= key_next;
        rp_reg  <= rp_next;
        wa_reg  <= wa_next;
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_RD) |-> (lo_reg <= hi_reg) && (hi_reg <= count_reg))
        else $error("search window out of order");

    a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && pend_reg) |-> (wa_reg != rp_reg))
        else $error("shift read and write hit the same entry");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_taken) |=> res_valid && $stable(res))
        else $error("result dropped or changed before hand-off");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready raised mid-operation");
`endif

endmodule

`default_nettype wire

// ===== hdl/sorted_set_insert_lookup_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Word
// input     in_valid/in_ready    mode[1:0], value[31:0] (signed)
// output    out_valid/out_ready  status[2:0], position[8:0], entry_count[8:0]
//
// A clear needs no table access; a lookup or a refused insert runs a binary
// search, each step a RAM read then a compare, and then reports its result.
// An accepted insert then shifts entries position..count-1 up by one and writes
// the value; every search step and shifted entry uses the single RAM read port.
// Reset clears the count, not the table; table contents are never read unwritten.
// A result waiting in the output register still lets a new word in; the input
// stalls while an operation runs or while the sequencer also holds an unsent result.

module sorted_set_insert_lookup_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    mode,
    input  wire logic signed [ssil_pkg::VAL_W-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         status,
    output logic [ssil_pkg::POS_W-1:0]         position,
    output logic [ssil_pkg::POS_W-1:0]         entry_count
);
    import ssil_pkg::*;

    // table RAM port signals
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [VAL_W-1:0]      rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VAL_W-1:0]      wr_data;

    // shared comparator
    logic signed [VAL_W-1:0] cmp_a;
    logic signed [VAL_W-1:0] cmp_b;
    cmp_t                    cmp_res;

    // result hand-off from sequencer to output register
    logic                  res_valid;
    logic                  res_taken;
    result_t               res;

    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;

    ssil_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ssil_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    ssil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (mode),
        .in_value  (value),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_res   (cmp_res),
        .res_valid (res_valid),
        .res_taken (res_taken),
        .res       (res)
    );

    // output slot frees when empty or being drained this cycle
    assign res_taken = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign position    = out_reg.position;
    assign entry_count = out_reg.entry_count;

endmodule

`default_nettype wire
